### sv/pbcd_pkg.sv
// Package for the packed BCD frequency codec: widths, codes, transaction
// and pipeline types, and the BCD digit helper functions.
// No dependencies.
package pbcd_pkg;

   // Field widths
   localparam int NUM_BYTES    = 5;
   localparam int DIGIT_W      = 4;
   localparam int NUM_DIGITS   = 2 * NUM_BYTES;
   localparam int FREQ_W       = 34;
   localparam int BCD_W        = 8 * NUM_BYTES;
   localparam int BYTE_CNT_W   = 3;
   localparam int DIGIT_CNT_W  = 4;

   // Each cell does two shift-and-adjust steps, so the chain covers every bit
   localparam int BITS_PER_CELL = 2;
   localparam int NUM_CELLS     = FREQ_W / BITS_PER_CELL;

   // Command codes
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   localparam logic [DIGIT_W-1:0] DIGIT_MASK   = 4'hF;
   localparam logic [DIGIT_W-1:0] ADJUST_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJUST_ADD   = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;

   typedef struct packed {
      logic                    command;
      logic [FREQ_W-1:0]       freq_hz;
      logic [BCD_W-1:0]        bcd_bytes;
      logic [BYTE_CNT_W-1:0]   byte_count;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0]       freq_out;
      logic [BCD_W-1:0]        bcd_out;
   } rsp_type;

   // Working word carried down the cell chain.
   // Encode: bin is the binary shift register, bcd the BCD accumulator.
   // Decode: bin is the binary accumulator, bcd the digits still to fold.
   typedef struct packed {
      logic                    command;
      logic [FREQ_W-1:0]       bin;
      logic [BCD_W-1:0]        bcd;
      logic [DIGIT_CNT_W-1:0]  digits_left;
   } stage_type;

   // Add three to every digit of five or more, ahead of a doubling shift
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0]   res;
      logic [DIGIT_W-1:0] dig;
      res = bcd;
      for (int j = 0; j < NUM_DIGITS; j++) begin
         dig = bcd[DIGIT_W*j +: DIGIT_W];
         if (dig >= ADJUST_LIMIT) begin
            res[DIGIT_W*j +: DIGIT_W] = dig + ADJUST_ADD;
         end
      end
      return res;
   endfunction

   // True when every nibble is a decimal digit
   function automatic logic bcd_digits_ok(input logic [BCD_W-1:0] bcd);
      logic ok;
      ok = 1'b1;
      for (int j = 0; j < NUM_DIGITS; j++) begin
         if ((bcd[DIGIT_W*j +: DIGIT_W] & DIGIT_MASK) > DIGIT_MAX) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

### sv/pbcd_cell.sv
// One cell of the codec chain: a registered stage doing two double-dabble
// steps when encoding or one decimal digit fold when decoding.
// Depends on pbcd_pkg.
module pbcd_cell
   import pbcd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic              valid_ff;
   logic              valid_in;
   stage_type         data_ff;
   stage_type         data_in;
   logic [BCD_W-1:0]  bcd_v;
   logic [FREQ_W-1:0] bin_v;

   // Stage takes a new transaction when empty or when its own one leaves
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Cell work
   always_comb begin
      bcd_v   = in_data.bcd;
      bin_v   = in_data.bin;
      data_in = in_data;
      if (in_data.command == CMD_ENCODE) begin
         for (int s = 0; s < BITS_PER_CELL; s++) begin
            bcd_v = bcd_adjust(bcd_v);
            {bcd_v, bin_v} = {bcd_v[BCD_W-2:0], bin_v, 1'b0};
         end
         data_in.bcd = bcd_v;
         data_in.bin = bin_v;
      end else if (in_data.digits_left != '0) begin
         // value * 10 + leading nibble
         data_in.bin = (bin_v << 3) + (bin_v << 1)
                       + FREQ_W'(bcd_v[BCD_W-1 -: DIGIT_W]);
         data_in.bcd = bcd_v << DIGIT_W;
         data_in.digits_left = in_data.digits_left - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### sv/packed_bcd_frequency_codec_core.sv
// Top level of the packed BCD frequency codec: request formatting, the
// chain of pbcd_cell stages and response formatting.
// Depends on pbcd_pkg and pbcd_cell.
//
// Usage:
//   req_* carries one transaction: command (encode or decode), freq_hz,
//   bcd_bytes and byte_count. rsp_* returns exactly one transaction for
//   each request, in order: freq_out (decode) or bcd_out (encode), the
//   other field zero.
//   The chain has 17 registered cells, each handling two binary bits of the
//   shift-and-add-three conversion, or one decimal digit when decoding.
//   Throughput is one transaction per cycle unless rsp_ready back-pressure
//   has filled the chain.
//   Each cell registers its transaction, so the last cell is the output
//   register. When rsp_ready is low the filled cells hold while empty ones
//   ahead of them keep filling; req_ready drops only once the whole chain
//   is full.
//   Reset empties the chain; there is no other state.
module packed_bcd_frequency_codec_core
   import pbcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                  link_valid [0:NUM_CELLS];
   logic                  link_ready [0:NUM_CELLS];
   stage_type             link_data  [0:NUM_CELLS];
   logic [BYTE_CNT_W-1:0] byte_count_sat;
   stage_type             last_data;

   // Request formatting: saturate the byte count, set up the work word
   always_comb begin
      byte_count_sat = (req_data.byte_count > BYTE_CNT_W'(NUM_BYTES))
                       ? BYTE_CNT_W'(NUM_BYTES) : req_data.byte_count;
      link_data[0].command = req_data.command;
      if (req_data.command == CMD_DECODE) begin
         link_data[0].bin         = '0;
         link_data[0].bcd         = req_data.bcd_bytes;
         link_data[0].digits_left = {byte_count_sat, 1'b0};
      end else begin
         link_data[0].bin         = req_data.freq_hz;
         link_data[0].bcd         = '0;
         link_data[0].digits_left = '0;
      end
   end

   assign link_valid[0] = req_valid;
   assign req_ready     = link_ready[0];

   // Cell chain
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      pbcd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   // Response formatting
   assign last_data             = link_data[NUM_CELLS];
   assign link_ready[NUM_CELLS] = rsp_ready;
   assign rsp_valid             = link_valid[NUM_CELLS];
   assign rsp_data.freq_out     = (last_data.command == CMD_DECODE) ? last_data.bin : '0;
   assign rsp_data.bcd_out      = (last_data.command == CMD_DECODE) ? '0 : last_data.bcd;

`ifndef ASSERT_OFF
   // A decode leaves the chain with every requested digit folded
   a_decode_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (last_data.command == CMD_DECODE) |-> last_data.digits_left == '0)
      else $error("decode left the chain with digits unfolded");

   // An encode always yields proper decimal digits
   a_encode_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (last_data.command == CMD_ENCODE) |-> bcd_digits_ok(last_data.bcd))
      else $error("encode produced a nibble above nine");

   // With the output cell empty the whole chain can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while output cell empty");

   // After reset the chain is empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");
`endif

endmodule

### verif/packed_bcd_frequency_codec_core_tb.sv
`timescale 1ns / 100ps
// Testbench for packed_bcd_frequency_codec_core: binary/packed BCD conversions
// checked against a behavioural converter, under varied idling and stalls.
// Depends on pbcd_pkg and the codec RTL.
module packed_bcd_frequency_codec_core_tb;
   import pbcd_pkg::*;

   localparam int unsigned DECIMAL_RADIX = 10;
   localparam int unsigned RANDOM_PER_PHASE = 133;
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned BYTE_CNT_MAX = (1 << BYTE_CNT_W) - 1;

   // Idling profiles, applied in turn to the random stimulus
   typedef enum int unsigned {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_RSP_STALLS,
      PH_BOTH_IDLE
   } idle_phase_e;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type     pending_req_q[$];
   idle_phase_e pending_phase_q[$];
   rsp_type     conv_expected_q[$];
   int unsigned send_gap_pct   = 0;
   int unsigned rsp_stall_pct  = 0;
   logic        req_fire       = 1'b0;
   int unsigned mismatch_count = 0;

   packed_bcd_frequency_codec_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Expected conversion result for one request
   function automatic rsp_type convert_freq(input req_type r);
      rsp_type     res;
      logic [63:0] val;
      int          used;
      res = '0;
      if (r.command == CMD_ENCODE) begin
         // keep the ten lowest decimal digits, least significant nibble last
         val = 64'(r.freq_hz);
         for (int k = 0; k < NUM_DIGITS; k++) begin
            res.bcd_out[DIGIT_W*k +: DIGIT_W] = DIGIT_W'(val % DECIMAL_RADIX);
            val = val / DECIMAL_RADIX;
         end
      end else begin
         // fold leading bytes, high nibble first; nibbles above nine taken as is
         used = (r.byte_count > BYTE_CNT_W'(NUM_BYTES)) ? NUM_BYTES : int'(r.byte_count);
         val = '0;
         for (int i = 0; i < used; i++) begin
            val = val * DECIMAL_RADIX + r.bcd_bytes[BCD_W-1-8*i -: DIGIT_W];
            val = val * DECIMAL_RADIX + r.bcd_bytes[BCD_W-1-DIGIT_W-8*i -: DIGIT_W];
         end
         res.freq_out = val[FREQ_W-1:0];
      end
      return res;
   endfunction

   function automatic int unsigned send_gap_of(input idle_phase_e ph);
      case (ph)
         PH_SEND_GAPS: return 59;
         PH_BOTH_IDLE: return 10;
         default:      return 0;
      endcase
   endfunction

   function automatic int unsigned rsp_stall_of(input idle_phase_e ph);
      case (ph)
         PH_RSP_STALLS: return 59;
         PH_BOTH_IDLE:  return 10;
         default:       return 0;
      endcase
   endfunction

   task automatic queue_req(input logic cmd, input logic [FREQ_W-1:0] freq,
                            input logic [BCD_W-1:0] bcd,
                            input logic [BYTE_CNT_W-1:0] cnt, input idle_phase_e ph);
      req_type r;
      r.command    = cmd;
      r.freq_hz    = freq;
      r.bcd_bytes  = bcd;
      r.byte_count = cnt;
      pending_req_q.push_back(r);
      pending_phase_q.push_back(ph);
   endtask

   // Request driver: new transaction at the falling edge once the last is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_data      <= pending_req_q.pop_front();
            send_gap_pct  <= send_gap_of(pending_phase_q[0]);
            rsp_stall_pct <= rsp_stall_of(pending_phase_q.pop_front());
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: log accepted requests, check accepted responses in order
   always @(posedge clock) begin
      rsp_type want;
      logic    bad;
      bad = 1'b0;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            conv_expected_q.push_back(convert_freq(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (conv_expected_q.size() == 0) begin
               $display("%0t: unexpected response freq_out=%h bcd_out=%h",
                        $realtime, rsp_data.freq_out, rsp_data.bcd_out);
               bad = 1'b1;
            end else begin
               want = conv_expected_q.pop_front();
               if (rsp_data.freq_out !== want.freq_out) begin
                  $display("%0t: freq_out mismatch, expected %h actual %h",
                           $realtime, want.freq_out, rsp_data.freq_out);
                  bad = 1'b1;
               end
               if (rsp_data.bcd_out !== want.bcd_out) begin
                  $display("%0t: bcd_out mismatch, expected %h actual %h",
                           $realtime, want.bcd_out, rsp_data.bcd_out);
                  bad = 1'b1;
               end
            end
         end
         if (bad) begin
            mismatch_count <= mismatch_count + 1;
         end
      end
   end

   // Hard stop
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      logic [FREQ_W-1:0] freq;
      logic [BCD_W-1:0]  bcd;
      logic [63:0]       wide;

      // Encode extremes: zero, widest input, ten-digit edges
      queue_req(CMD_ENCODE, '0, '0, '0, PH_STEADY);
      queue_req(CMD_ENCODE, '1, '1, '1, PH_STEADY);
      queue_req(CMD_ENCODE, 34'd9999999999, '0, 3'd5, PH_STEADY);
      queue_req(CMD_ENCODE, 34'd10000000000, 40'h1234567890, '0, PH_STEADY);
      queue_req(CMD_ENCODE, 34'd1234567890, '0, '0, PH_STEADY);
      queue_req(CMD_ENCODE, 34'd5000000001, 40'hFFFFFFFFFF, 3'd7, PH_STEADY);
      // Decode: every byte count, saturation, zero count, nibbles above nine
      queue_req(CMD_DECODE, '1, 40'hFFFFFFFFFF, 3'd0, PH_STEADY);
      for (int c = 1; c <= BYTE_CNT_MAX; c++) begin
         queue_req(CMD_DECODE, '0, 40'h1234567890, c[BYTE_CNT_W-1:0], PH_STEADY);
      end
      queue_req(CMD_DECODE, '0, 40'h9999999999, 3'd6, PH_STEADY);
      queue_req(CMD_DECODE, '0, 40'hFFFFFFFFFF, 3'd5, PH_STEADY);
      queue_req(CMD_DECODE, '1, 40'h0000000000, 3'd5, PH_STEADY);
      queue_req(CMD_DECODE, '0, 40'hA0B0C0D0E0, 3'd5, PH_STEADY);
      queue_req(CMD_DECODE, '1, 40'h0F0F0F0F0F, 3'd7, PH_STEADY);

      // Random transactions, one block per idling profile
      for (int p = PH_STEADY; p <= PH_BOTH_IDLE; p++) begin
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            wide = {$urandom, $urandom};
            case ($urandom_range(3))
               0:       freq = wide[FREQ_W-1:0];
               1:       freq = 34'd10000000000 - 34'd50 + FREQ_W'($urandom_range(100));
               2:       freq = FREQ_W'($urandom_range(99999));
               default: freq = wide[FREQ_W-1:0] | 34'h200000000;
            endcase
            wide = {$urandom, $urandom};
            bcd = wide[BCD_W-1:0];
            if ($urandom_range(1) == 0) begin
               // mostly well-formed digits
               for (int d = 0; d < NUM_DIGITS; d++) begin
                  bcd[DIGIT_W*d +: DIGIT_W] = DIGIT_W'($urandom_range(9));
               end
            end
            queue_req(1'($urandom_range(1)), freq, bcd,
                      BYTE_CNT_W'($urandom_range(BYTE_CNT_MAX)), idle_phase_e'(p));
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last request to go, then for every response
      while (pending_req_q.size() != 0 || req_valid) @(negedge clock);
      while (conv_expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
